[sv/psrm_pkg.sv]
// ----------------------------------------------------------------------------
// psrm_pkg: shared definitions for the packet slot ring manager
// Field widths, parameter defaults, request codes and the controller states.
// ----------------------------------------------------------------------------
package psrm_pkg;

    // Fixed field widths of the ports.
    localparam int CFG_W  = 11;
    localparam int LEN_W  = 11;
    localparam int SLOT_W = 10;

    // Parameter defaults.
    localparam int SLOT_COUNT_DEF  = 1024;
    localparam int MAX_PAYLOAD_DEF = 1496;

    // Reset value of the ring size register.
    localparam int RING_SIZE_RST = 1024;

    // Request codes.
    localparam logic REQ_STORE = 1'b0;
    localparam logic REQ_FETCH = 1'b1;

    // Controller states.
    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } t_state;

endpackage

[sv/psrm_ram.sv]
// ----------------------------------------------------------------------------
// psrm_ram: generic simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module psrm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read port.
    always_ff @(posedge i_clk) begin
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

[sv/packet_slot_ring_manager_top.sv]
// ----------------------------------------------------------------------------
// packet_slot_ring_manager_top: slot ring with occupancy search
// Keeps the length of every packet slot in a RAM and walks the ring from the
// write or read pointer to find the first empty or occupied slot.
//
//   Channel   Direction  Handshake                   Payload
//   request   in         i_in_valid / o_in_ready     i_req_type, i_packet_length
//   result    out        o_out_valid / i_out_ready   o_slot_number, o_stored_length
//   config    in         i_cfg_we                    i_cfg_data (slots in use)
//
// A request probes k slots, k from 1 to ring size - 1: the first read is
// issued as the request is accepted, the length RAM is read one slot per cycle
// on its single read port, and the finish state moves the answer out.
// After reset a clearing pass zeroes every slot of the length RAM;
// no request is taken during it, while configuration writes are.
// A result waits in the output register; a finished answer holds in the
// controller until that register is free.
// ----------------------------------------------------------------------------
module packet_slot_ring_manager_top #(
    parameter int SLOT_COUNT  = psrm_pkg::SLOT_COUNT_DEF,
    parameter int MAX_PAYLOAD = psrm_pkg::MAX_PAYLOAD_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // Configuration
    input  logic                        i_cfg_we,
    input  logic [psrm_pkg::CFG_W-1:0]  i_cfg_data,
    // Request channel
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic                        i_req_type,
    input  logic [psrm_pkg::LEN_W-1:0]  i_packet_length,
    // Result channel
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic [psrm_pkg::SLOT_W-1:0] o_slot_number,
    output logic [psrm_pkg::LEN_W-1:0]  o_stored_length
);

    localparam int AW = $clog2(SLOT_COUNT);
    localparam int NW = $clog2(SLOT_COUNT + 1);
    localparam int EW = (NW > psrm_pkg::CFG_W) ? NW : psrm_pkg::CFG_W;
    localparam int LW = psrm_pkg::LEN_W;

    localparam logic [EW-1:0] RING_MIN   = EW'(2);
    localparam logic [EW-1:0] RING_MAX   = EW'(SLOT_COUNT);
    localparam logic [AW-1:0] SLOT_FIRST = AW'(1);
    localparam logic [AW-1:0] SLOT_LAST  = AW'(SLOT_COUNT - 1);
    localparam logic [LW-1:0] LEN_MAX    = LW'(MAX_PAYLOAD);

    // Registers.
    psrm_pkg::t_state r_state, n_state;
    logic [psrm_pkg::CFG_W-1:0] r_slots_in_use;
    logic [AW-1:0] r_wr_ptr, n_wr_ptr;
    logic [AW-1:0] r_rd_ptr, n_rd_ptr;
    logic [AW-1:0] r_clr, n_clr;
    logic [AW-1:0] r_cur, n_cur;
    logic [EW-1:0] r_cnt, n_cnt;
    logic          r_req, n_req;
    logic [LW-1:0] r_len, n_len;
    logic [AW-1:0] r_res_slot, n_res_slot;
    logic [LW-1:0] r_res_len, n_res_len;
    logic          r_out_valid, n_out_valid;
    logic [AW-1:0] r_out_slot, n_out_slot;
    logic [LW-1:0] r_out_len, n_out_len;

    // RAM ports and helpers.
    logic          ram_wr_en;
    logic [AW-1:0] ram_wr_addr;
    logic [LW-1:0] ram_wr_data;
    logic [AW-1:0] ram_rd_addr;
    logic [LW-1:0] ram_rd_data;
    logic [EW-1:0] ring_n;
    logic [EW-1:0] cfg_ext;
    logic [AW-1:0] start_ptr;
    logic [AW-1:0] start_slot;
    logic [EW-1:0] cur_inc;
    logic [AW-1:0] cur_next;
    logic          hit;
    logic          out_free;
    logic          accept;

    psrm_ram #(
        .WIDTH (LW),
        .DEPTH (SLOT_COUNT)
    ) u_len_ram (
        .i_clk     (i_clk),
        .i_wr_en   (ram_wr_en),
        .i_wr_addr (ram_wr_addr),
        .i_wr_data (ram_wr_data),
        .i_rd_addr (ram_rd_addr),
        .o_rd_data (ram_rd_data)
    );

    // Effective ring size, clamped to the legal range.
    always_comb begin
        cfg_ext = EW'(r_slots_in_use);
        if (cfg_ext < RING_MIN) begin
            ring_n = RING_MIN;
        end else if (cfg_ext > RING_MAX) begin
            ring_n = RING_MAX;
        end else begin
            ring_n = cfg_ext;
        end
    end

    // First slot to probe for an incoming request.
    assign start_ptr  = (i_req_type == psrm_pkg::REQ_FETCH) ? r_rd_ptr : r_wr_ptr;
    assign start_slot = ((start_ptr == '0) || (EW'(start_ptr) >= ring_n)) ?
                        SLOT_FIRST : start_ptr;

    // Successor of the slot being probed, wrapping back to slot 1.
    assign cur_inc  = EW'(r_cur) + EW'(1);
    assign cur_next = (cur_inc >= ring_n) ? SLOT_FIRST : AW'(cur_inc);

    // A fetch looks for an occupied slot, a store for an empty one.
    assign hit = ((ram_rd_data != '0) == (r_req == psrm_pkg::REQ_FETCH));

    assign out_free   = !r_out_valid || i_out_ready;
    assign o_in_ready = (r_state == psrm_pkg::ST_IDLE);
    assign accept     = i_in_valid && o_in_ready;

    // Configuration register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slots_in_use <= psrm_pkg::CFG_W'(psrm_pkg::RING_SIZE_RST);
        end else if (i_cfg_we) begin
            r_slots_in_use <= i_cfg_data;
        end
    end

    // State and control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= psrm_pkg::ST_CLEAR;
            r_wr_ptr    <= SLOT_FIRST;
            r_rd_ptr    <= SLOT_FIRST;
            r_clr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_wr_ptr    <= n_wr_ptr;
            r_rd_ptr    <= n_rd_ptr;
            r_clr       <= n_clr;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_cur      <= n_cur;
        r_cnt      <= n_cnt;
        r_req      <= n_req;
        r_len      <= n_len;
        r_res_slot <= n_res_slot;
        r_res_len  <= n_res_len;
        r_out_slot <= n_out_slot;
        r_out_len  <= n_out_len;
    end

    // Next state, RAM access and result handling.
    always_comb begin
        n_state     = r_state;
        n_wr_ptr    = r_wr_ptr;
        n_rd_ptr    = r_rd_ptr;
        n_clr       = r_clr;
        n_cur       = r_cur;
        n_cnt       = r_cnt;
        n_req       = r_req;
        n_len       = r_len;
        n_res_slot  = r_res_slot;
        n_res_len   = r_res_len;
        n_out_valid = r_out_valid;
        n_out_slot  = r_out_slot;
        n_out_len   = r_out_len;
        ram_wr_en   = 1'b0;
        ram_wr_addr = r_cur;
        ram_wr_data = '0;
        ram_rd_addr = cur_next;

        // The output register empties on a transfer.
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            psrm_pkg::ST_CLEAR: begin
                // Zero one slot per cycle after reset.
                ram_wr_en   = 1'b1;
                ram_wr_addr = r_clr;
                if (r_clr == SLOT_LAST) begin
                    n_state = psrm_pkg::ST_IDLE;
                end else begin
                    n_clr = r_clr + AW'(1);
                end
            end
            psrm_pkg::ST_IDLE: begin
                // Issue the read of the first slot as the request is taken.
                ram_rd_addr = start_slot;
                if (accept) begin
                    n_state = psrm_pkg::ST_SCAN;
                    n_cur   = start_slot;
                    n_cnt   = ring_n - EW'(1);
                    n_req   = i_req_type;
                    n_len   = (i_packet_length > LEN_MAX) ? LEN_MAX : i_packet_length;
                end
            end
            psrm_pkg::ST_SCAN: begin
                // Check the slot whose length just came out of the RAM.
                if (hit) begin
                    ram_wr_en  = 1'b1;
                    n_res_slot = r_cur;
                    n_state    = psrm_pkg::ST_FINISH;
                    if (r_req == psrm_pkg::REQ_FETCH) begin
                        ram_wr_data = '0;
                        n_res_len   = ram_rd_data;
                        n_rd_ptr    = cur_next;
                    end else begin
                        ram_wr_data = r_len;
                        n_res_len   = '0;
                        n_wr_ptr    = cur_next;
                    end
                end else if (r_cnt == EW'(1)) begin
                    // Whole ring probed without a match.
                    n_res_slot = '0;
                    n_res_len  = '0;
                    n_state    = psrm_pkg::ST_FINISH;
                end else begin
                    n_cur = cur_next;
                    n_cnt = r_cnt - EW'(1);
                end
            end
            psrm_pkg::ST_FINISH: begin
                // Hand the answer to the output register once it is free.
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_slot  = r_res_slot;
                    n_out_len   = r_res_len;
                    n_state     = psrm_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = psrm_pkg::ST_IDLE;
            end
        endcase
    end

    assign o_out_valid     = r_out_valid;
    assign o_slot_number   = psrm_pkg::SLOT_W'(r_out_slot);
    assign o_stored_length = r_out_len;

endmodule

[tb/sv/psrm_result_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psrm_result_checker: answer predictor and scoreboard for the slot ring
// Watches the configuration port and both channels of the slot ring manager.
// It keeps its own copy of the slot lengths, the two pointers and the ring size.
// Every accepted request is turned into the expected answer.
// Every result transfer is compared, field by field, with the oldest answer.
// ----------------------------------------------------------------------------
module psrm_result_checker (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [psrm_pkg::CFG_W-1:0]  i_cfg_data,
    input  logic                        i_in_valid,
    input  logic                        i_in_ready,
    input  logic                        i_req_type,
    input  logic [psrm_pkg::LEN_W-1:0]  i_packet_length,
    input  logic                        i_out_valid,
    input  logic                        i_out_ready,
    input  logic [psrm_pkg::SLOT_W-1:0] i_slot_number,
    input  logic [psrm_pkg::LEN_W-1:0]  i_stored_length,
    output int                          o_mismatch_count,
    output int                          o_outstanding
);

    localparam int SLOT_COUNT  = psrm_pkg::SLOT_COUNT_DEF;
    localparam int MAX_PAYLOAD = psrm_pkg::MAX_PAYLOAD_DEF;
    localparam int PRINT_CAP   = 40;

    typedef struct packed {
        logic [psrm_pkg::SLOT_W-1:0] slot;
        logic [psrm_pkg::LEN_W-1:0]  length;
    } t_slot_answer;

    // Model state of the ring.
    logic [psrm_pkg::LEN_W-1:0]  slot_len [SLOT_COUNT];
    logic [psrm_pkg::SLOT_W-1:0] wr_ptr;
    logic [psrm_pkg::SLOT_W-1:0] rd_ptr;
    logic [psrm_pkg::CFG_W-1:0]  ring_cfg;

    t_slot_answer answer_q [$];
    int           mismatch_count = 0;

    initial o_outstanding = 0;
    assign o_mismatch_count = mismatch_count;

    // Prints one line for a mismatch and counts it.
    task automatic report_mismatch(input string what, input logic [31:0] want,
                                   input logic [31:0] seen);
        if (mismatch_count < PRINT_CAP)
            $display("[%0t] mismatch: %s expected %0d got %0d", $time, what, want, seen);
        mismatch_count++;
    endtask

    // Slot after s, wrapping from the last slot in use back to slot 1.
    function automatic logic [psrm_pkg::SLOT_W-1:0] step_ring(input int s, input int n);
        return (s + 1 >= n) ? psrm_pkg::SLOT_W'(1) : psrm_pkg::SLOT_W'(s + 1);
    endfunction

    // First slot from start whose occupancy matches want_full, or 0 if none.
    // A start pointer that lies outside the ring starts the walk at slot 1.
    function automatic logic [psrm_pkg::SLOT_W-1:0] find_slot(input int start, input int n,
                                                              input bit want_full);
        int s;
        s = (start == 0 || start >= n) ? 1 : start;
        for (int k = 1; k < n; k++) begin
            if ((slot_len[s] != '0) == want_full)
                return psrm_pkg::SLOT_W'(s);
            s = int'(step_ring(s, n));
        end
        return '0;
    endfunction

    always @(posedge i_clk) begin
        t_slot_answer want;
        int ring;
        logic [psrm_pkg::LEN_W-1:0] len;
        if (!i_rst_n) begin
            ring_cfg = psrm_pkg::CFG_W'(psrm_pkg::RING_SIZE_RST);
            for (int i = 0; i < SLOT_COUNT; i++)
                slot_len[i] = '0;
            wr_ptr = psrm_pkg::SLOT_W'(1);
            rd_ptr = psrm_pkg::SLOT_W'(1);
            answer_q.delete();
        end else begin
            // Result transfer: compare with the oldest expected answer.
            if (i_out_valid && i_out_ready) begin
                if (answer_q.size() == 0) begin
                    report_mismatch("result with nothing outstanding, slot", 32'd0,
                                    32'(i_slot_number));
                end else begin
                    want = answer_q.pop_front();
                    if (i_slot_number !== want.slot)
                        report_mismatch("slot_number", 32'(want.slot), 32'(i_slot_number));
                    if (i_stored_length !== want.length)
                        report_mismatch("stored_length", 32'(want.length),
                                        32'(i_stored_length));
                end
            end

            // Request transfer: work out the answer and update the ring.
            if (i_in_valid && i_in_ready) begin
                ring = int'(ring_cfg);
                if (ring < 2)
                    ring = 2;
                if (ring > SLOT_COUNT)
                    ring = SLOT_COUNT;
                want.length = '0;
                if (i_req_type == psrm_pkg::REQ_STORE) begin
                    len = (i_packet_length > psrm_pkg::LEN_W'(MAX_PAYLOAD)) ?
                          psrm_pkg::LEN_W'(MAX_PAYLOAD) : i_packet_length;
                    want.slot = find_slot(int'(wr_ptr), ring, 1'b0);
                    if (want.slot != '0) begin
                        slot_len[want.slot] = len;
                        wr_ptr = step_ring(int'(want.slot), ring);
                    end
                end else begin
                    want.slot = find_slot(int'(rd_ptr), ring, 1'b1);
                    if (want.slot != '0) begin
                        want.length = slot_len[want.slot];
                        slot_len[want.slot] = '0;
                        rd_ptr = step_ring(int'(want.slot), ring);
                    end
                end
                answer_q.push_back(want);
            end

            // A ring size write takes effect for the requests after this edge.
            if (i_cfg_we)
                ring_cfg = i_cfg_data;
        end
        o_outstanding <= answer_q.size();
    end

endmodule

[tb/sv/tb_packet_slot_ring_manager_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_packet_slot_ring_manager_top: regression bench for the slot ring manager
// Drives store and fetch requests in bursts with random gaps, stalls the
// result side on changing patterns and moves the ring size between phases.
// A directed opening covers the edge cases; random phases follow. The checker
// beside the block predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_packet_slot_ring_manager_top;

    localparam longint TIMEOUT_NS   = 64'd50_000_000;
    localparam int     RANDOM_ITEMS = 700;
    localparam int     DRAIN_CYCLES = 1100;

    typedef enum int {
        RX_ALWAYS,
        RX_PATTERN,
        RX_RANDOM,
        RX_SLOW
    } t_rx_mode;

    logic                        clk           = 1'b0;
    logic                        rst_n         = 1'b0;
    logic                        cfg_we        = 1'b0;
    logic [psrm_pkg::CFG_W-1:0]  cfg_data      = '0;
    logic                        in_valid      = 1'b0;
    logic                        in_ready;
    logic                        req_type      = psrm_pkg::REQ_STORE;
    logic [psrm_pkg::LEN_W-1:0]  packet_length = '0;
    logic                        out_valid;
    logic                        out_ready     = 1'b0;
    logic [psrm_pkg::SLOT_W-1:0] slot_number;
    logic [psrm_pkg::LEN_W-1:0]  stored_length;
    int                          mismatches;
    int                          outstanding;

    int burst_left;
    int random_sent;

    packet_slot_ring_manager_top DUT (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_cfg_we        (cfg_we),
        .i_cfg_data      (cfg_data),
        .i_in_valid      (in_valid),
        .o_in_ready      (in_ready),
        .i_req_type      (req_type),
        .i_packet_length (packet_length),
        .o_out_valid     (out_valid),
        .i_out_ready     (out_ready),
        .o_slot_number   (slot_number),
        .o_stored_length (stored_length)
    );

    psrm_result_checker u_checker (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_cfg_we         (cfg_we),
        .i_cfg_data       (cfg_data),
        .i_in_valid       (in_valid),
        .i_in_ready       (in_ready),
        .i_req_type       (req_type),
        .i_packet_length  (packet_length),
        .i_out_valid      (out_valid),
        .i_out_ready      (out_ready),
        .i_slot_number    (slot_number),
        .i_stored_length  (stored_length),
        .o_mismatch_count (mismatches),
        .o_outstanding    (outstanding)
    );

    // Clock: 12 ns period.
    always begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Result side: a randomly drawn stall mode and pattern that change as the run goes on.
    int        rx_tick    = 0;
    logic [15:0] rx_pattern = 16'hFFFF;
    t_rx_mode  rx_mode    = RX_ALWAYS;

    always @(posedge clk) begin
        if (rx_tick % 64 == 0) begin
            rx_mode    = t_rx_mode'($urandom_range(0, 3));
            rx_pattern = 16'($urandom()) | 16'h0001;
        end
        case (rx_mode)
            RX_ALWAYS:  out_ready <= 1'b1;
            RX_PATTERN: out_ready <= rx_pattern[rx_tick % 16];
            RX_RANDOM:  out_ready <= ($urandom_range(0, 3) != 0);
            default:    out_ready <= (rx_tick % 32 == 0);
        endcase
        rx_tick++;
    end

    // One request transfer; a burst ends with a random gap on the sender side.
    task automatic send_request(input logic req, input logic [psrm_pkg::LEN_W-1:0] len);
        int gap;
        in_valid      <= 1'b1;
        req_type      <= req;
        packet_length <= len;
        do @(posedge clk); while (!in_ready);
        burst_left--;
        if (burst_left <= 0) begin
            gap = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 4);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 60)
                                                     : $urandom_range(1, 10);
        end
    endtask

    // Holds the sender back until every outstanding answer has arrived.
    task automatic wait_idle();
        in_valid <= 1'b0;
        do @(posedge clk); while (outstanding != 0);
    endtask

    // Ring size write once the block is idle.
    task automatic write_ring_size(input logic [psrm_pkg::CFG_W-1:0] value);
        wait_idle();
        cfg_data <= value;
        cfg_we   <= 1'b1;
        @(posedge clk);
        cfg_we   <= 1'b0;
    endtask

    // Stimulus and verdict.
    initial begin
        int pick;
        int items;
        int store_pct;
        logic [psrm_pkg::CFG_W-1:0] ring;
        logic [psrm_pkg::LEN_W-1:0] len;
        logic req;

        burst_left  = $urandom_range(1, 10);
        random_sent = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // Full-size ring after reset: fetch from an empty ring, then stores with
        // oversized, zero and boundary lengths, then two fetches, the second of
        // which skips the zero-length slot.
        send_request(psrm_pkg::REQ_FETCH, 11'd2047);
        send_request(psrm_pkg::REQ_STORE, 11'd2047);
        send_request(psrm_pkg::REQ_STORE, 11'd0);
        send_request(psrm_pkg::REQ_STORE, 11'd1496);
        send_request(psrm_pkg::REQ_STORE, 11'd1);
        send_request(psrm_pkg::REQ_STORE, 11'd1024);
        send_request(psrm_pkg::REQ_STORE, 11'd512);
        send_request(psrm_pkg::REQ_FETCH, 11'd0);
        send_request(psrm_pkg::REQ_FETCH, 11'd1497);

        // Shrink the ring below both pointers: walks restart at slot 1, the ring
        // fills up and empties, slots beyond it keep their lengths.
        write_ring_size(11'd3);
        send_request(psrm_pkg::REQ_STORE, 11'd100);
        send_request(psrm_pkg::REQ_STORE, 11'd200);
        send_request(psrm_pkg::REQ_STORE, 11'd300);
        send_request(psrm_pkg::REQ_FETCH, 11'd2047);
        send_request(psrm_pkg::REQ_FETCH, 11'd0);
        send_request(psrm_pkg::REQ_FETCH, 11'd5);

        // Ring size below the minimum is taken as two slots.
        write_ring_size(11'd0);
        send_request(psrm_pkg::REQ_STORE, 11'd1);
        send_request(psrm_pkg::REQ_STORE, 11'd2);
        send_request(psrm_pkg::REQ_FETCH, 11'd0);

        // Ring size above the slot count; the slots left outside come back.
        write_ring_size(11'd2047);
        send_request(psrm_pkg::REQ_FETCH, 11'd0);
        send_request(psrm_pkg::REQ_FETCH, 11'd0);
        send_request(psrm_pkg::REQ_FETCH, 11'd0);

        // Random phases, mostly on small rings.
        while (random_sent < RANDOM_ITEMS) begin
            pick = $urandom_range(0, 99);
            if (pick < 55)
                ring = psrm_pkg::CFG_W'($urandom_range(2, 16));
            else if (pick < 75)
                ring = psrm_pkg::CFG_W'($urandom_range(17, 100));
            else if (pick < 82)
                ring = psrm_pkg::CFG_W'($urandom_range(0, 1));
            else if (pick < 88)
                ring = psrm_pkg::CFG_W'($urandom_range(1023, 1024));
            else if (pick < 94)
                ring = psrm_pkg::CFG_W'($urandom_range(1025, 2047));
            else
                ring = psrm_pkg::CFG_W'($urandom_range(101, 1022));
            write_ring_size(ring);
            items     = (ring > 100) ? $urandom_range(10, 25) : $urandom_range(20, 60);
            store_pct = $urandom_range(25, 75);
            repeat (items) begin
                case ($urandom_range(0, 9))
                    0:       len = '0;
                    1:       len = psrm_pkg::LEN_W'($urandom_range(1496, 2047));
                    default: len = psrm_pkg::LEN_W'($urandom_range(0, 2047));
                endcase
                req = ($urandom_range(0, 99) < store_pct) ? psrm_pkg::REQ_STORE
                                                          : psrm_pkg::REQ_FETCH;
                send_request(req, len);
                random_sent++;
                if (random_sent == RANDOM_ITEMS / 2 || $urandom_range(0, 59) == 0)
                    wait_idle();
            end
        end

        // Drain, then let the block sit for a full ring walk.
        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0 && outstanding == 0)
            $display("packet_slot_ring_manager_top regression: pass");
        else
            $display("packet_slot_ring_manager_top regression: fail");
        $finish;
    end

    // Watchdog against a hung handshake.
    initial begin
        #(TIMEOUT_NS);
        $display("packet_slot_ring_manager_top regression: fail");
        $finish;
    end

endmodule
